>>> rtl/core/tpcs_pkg.sv
// Package with the shared types and constants of the collinearity search.
`timescale 1ns / 1ps
package tpcs_pkg;
	localparam int CoordW = 16;
	localparam int DiffW = CoordW + 1;
	localparam int ProdW = 2 * DiffW;
	localparam int IdxOutW = 6;
	localparam int InDataW = 32;
	localparam int OutDataW = 24;

	typedef logic signed [DiffW-1:0] diff_t;
	typedef logic signed [ProdW-1:0] prod_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_P_RD,
		ST_P_WAIT,
		ST_A_RD,
		ST_A_WAIT,
		ST_B_RD,
		ST_B_WAIT,
		ST_MUL1,
		ST_MUL2,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic capture;
		logic use_b_pair;
	} cross_ctl_t;
endpackage

>>> rtl/core/tpcs_store.sv
// Point memory: one write port and one registered read port.
`timescale 1ns / 1ps
module tpcs_store import tpcs_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
	input  logic [InDataW-1:0]            wr_data,
	input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	output logic [InDataW-1:0]            rd_data
);
	logic [InDataW-1:0] mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> rtl/core/tpcs_cross.sv
// Shared multiplier: holds the first cross term and compares the second against it.
`timescale 1ns / 1ps
module tpcs_cross import tpcs_pkg::*; (
	input  logic       clk,
	input  cross_ctl_t ctl,
	input  diff_t      ax,
	input  diff_t      ay,
	input  diff_t      bx,
	input  diff_t      by,
	output logic       equal
);
	diff_t op_l;
	diff_t op_r;
	prod_t prod;
	prod_t first_q;

	// First pass forms ax*by, second pass forms ay*bx on the same multiplier.
	assign op_l = ctl.use_b_pair ? ay : ax;
	assign op_r = ctl.use_b_pair ? bx : by;
	assign prod = op_l * op_r;
	assign equal = (prod == first_q);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			first_q <= prod;
		end
	end
endmodule

>>> rtl/core/three_point_collinearity_search_top.sv
// Top level of the three-point collinearity search with its search sequencer.
//
//  Channel | Direction | Signals                    | Contents
//  s_*     | in        | s_tvalid s_tready s_tdata  | point_x [15:0], point_y [31:16]
//          |           | s_tlast                    | last_point
//  m_*     | out       | m_tvalid m_tready m_tdata  | found, pivot, second, third, overflow
//
// Points are taken one beat per cycle while the block is loading. The beat that
// carries tlast starts the search, during which the input is not ready. The
// search visits pivot p, partner a and partner b in load order; each (p, a, b)
// test runs through a memory read, a difference latch and two passes through
// the single shared multiplier. Each partner a and each pivot p is read, then
// latched, and then its inner loop is found exhausted. A search that finds
// nothing ends with a closing pivot check, after which the verdict moves into
// the output register. The verdict waits there until it is taken while the next
// set loads; a further verdict waits for that register to drain. Reset clears
// the sequencer, count, flags and output register; the point memory itself is
// never cleared.
`timescale 1ns / 1ps
module three_point_collinearity_search_top import tpcs_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // point_x [15:0], point_y [31:16]
	input  logic                s_tlast,   // last_point
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata    // found [0], pivot_index [6:1],
	                                       // second_index [12:7], third_index [18:13],
	                                       // overflow [19], zeros [23:20]
);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int IW = $clog2(MAX_POINTS + 2);

	seq_state_t state_q, state_nx;
	logic [IW-1:0] count_q, p_q, a_q, b_q;
	logic          dropped_q;
	logic          found_q;
	logic [IdxOutW-1:0] pi_q, ai_q, bi_q;
	logic [CoordW-1:0]  px_q, py_q;
	diff_t ax_q, ay_q, bx_q, by_q;

	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;
	logic                out_free;

	logic [AW-1:0]      rd_addr;
	logic [InDataW-1:0] rd_data;
	logic               wr_en;
	logic               accept;
	cross_ctl_t         xctl;
	logic               equal;

	logic [IW-1:0] a_inc, a_nxt, b_inc, b_nxt, b_first;
	logic [IW+IdxOutW-1:0] p_ext, a_ext, b_ext;

	assign accept = s_tvalid && s_tready;
	assign wr_en = accept && (count_q < IW'(MAX_POINTS));

	// The output register can take a verdict when empty or when its beat leaves now.
	assign out_free = !out_valid_q || m_tready;

	// Partner indices step over the pivot.
	assign a_inc = a_q + IW'(1);
	assign a_nxt = (a_inc == p_q) ? a_q + IW'(2) : a_inc;
	assign b_inc = b_q + IW'(1);
	assign b_nxt = (b_inc == p_q) ? b_q + IW'(2) : b_inc;
	assign b_first = (a_inc == p_q) ? a_q + IW'(2) : a_inc;

	assign p_ext = {{IdxOutW{1'b0}}, p_q};
	assign a_ext = {{IdxOutW{1'b0}}, a_q};
	assign b_ext = {{IdxOutW{1'b0}}, b_q};

	tpcs_store #(.MAX_POINTS(MAX_POINTS)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (s_tdata),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tpcs_cross u_cross (
		.clk   (clk),
		.ctl   (xctl),
		.ax    (ax_q),
		.ay    (ay_q),
		.bx    (bx_q),
		.by    (by_q),
		.equal (equal)
	);

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && s_tlast) state_nx = ST_P_RD;
			end
			ST_P_RD: begin
				state_nx = (p_q >= count_q) ? ST_OUT : ST_P_WAIT;
			end
			ST_P_WAIT: state_nx = ST_A_RD;
			ST_A_RD: begin
				state_nx = (a_q >= count_q) ? ST_P_RD : ST_A_WAIT;
			end
			ST_A_WAIT: state_nx = ST_B_RD;
			ST_B_RD: begin
				state_nx = (b_q >= count_q) ? ST_A_RD : ST_B_WAIT;
			end
			ST_B_WAIT: state_nx = ST_MUL1;
			ST_MUL1:   state_nx = ST_MUL2;
			ST_MUL2: begin
				state_nx = equal ? ST_OUT : ST_B_RD;
			end
			ST_OUT: begin
				if (out_free) state_nx = ST_LOAD;
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		s_tready = 1'b0;
		rd_addr = p_q[AW-1:0];
		xctl = '0;
		unique case (state_q)
			ST_LOAD: s_tready = 1'b1;
			ST_P_RD: rd_addr = p_q[AW-1:0];
			ST_A_RD: rd_addr = a_q[AW-1:0];
			ST_B_RD: rd_addr = b_q[AW-1:0];
			ST_MUL1: xctl.capture = 1'b1;
			ST_MUL2: xctl.use_b_pair = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			found_q   <= 1'b0;
			p_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (wr_en) count_q <= count_q + IW'(1);
						else       dropped_q <= 1'b1;
					end
					found_q <= 1'b0;
					p_q <= '0;
				end
				ST_P_WAIT: begin
					a_q <= (p_q == '0) ? IW'(1) : '0;
				end
				ST_A_RD: begin
					if (a_q >= count_q) p_q <= p_q + IW'(1);
					else                b_q <= b_first;
				end
				ST_B_RD: begin
					if (b_q >= count_q) a_q <= a_nxt;
				end
				ST_MUL2: begin
					if (equal) found_q <= 1'b1;
					else       b_q <= b_nxt;
				end
				ST_OUT: begin
					if (out_free) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: a verdict that finds nothing carries zero indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {4'b0000, dropped_q,
				                found_q ? bi_q : {IdxOutW{1'b0}},
				                found_q ? ai_q : {IdxOutW{1'b0}},
				                found_q ? pi_q : {IdxOutW{1'b0}},
				                found_q};
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: coordinates, difference vectors and reported indices.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_P_WAIT: begin
				px_q <= rd_data[CoordW-1:0];
				py_q <= rd_data[InDataW-1:CoordW];
			end
			ST_A_WAIT: begin
				ax_q <= diff_t'($signed({rd_data[CoordW-1], rd_data[CoordW-1:0]}))
				      - diff_t'($signed({px_q[CoordW-1], px_q}));
				ay_q <= diff_t'($signed({rd_data[InDataW-1], rd_data[InDataW-1:CoordW]}))
				      - diff_t'($signed({py_q[CoordW-1], py_q}));
			end
			ST_B_WAIT: begin
				bx_q <= diff_t'($signed({rd_data[CoordW-1], rd_data[CoordW-1:0]}))
				      - diff_t'($signed({px_q[CoordW-1], px_q}));
				by_q <= diff_t'($signed({rd_data[InDataW-1], rd_data[InDataW-1:CoordW]}))
				      - diff_t'($signed({py_q[CoordW-1], py_q}));
			end
			ST_MUL2: begin
				pi_q <= p_ext[IdxOutW-1:0];
				ai_q <= a_ext[IdxOutW-1:0];
				bi_q <= b_ext[IdxOutW-1:0];
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
endmodule
